// ===== rtl/irs_pkg.sv =====
// Package for the intrinsic reward scorer: constants, state machine type.
// No dependencies.
`default_nettype none
package irs_pkg;
    localparam int unsigned HistDepth = 32;
    localparam int unsigned MaxDim    = 64;
    localparam int unsigned HistW     = $clog2(HistDepth);
    localparam int unsigned DimW      = $clog2(MaxDim);
    localparam logic [15:0] AlphaQ16  = 16'd655;
    localparam logic [15:0] EpsQ12    = 16'd41;
    localparam logic [15:0] WNov      = 16'd9830;
    localparam logic [15:0] WProg     = 16'd13107;
    localparam logic [15:0] WCons     = 16'd9830;
    localparam logic [16:0] OneQ15    = 17'd32768;

    typedef enum logic [3:0] {
        S_IDLE, S_ELEM, S_RING, S_HIST, S_SUMS, S_NOVDIV, S_PROGDIV,
        S_MEAN, S_SQRT, S_CONSDIV, S_MIX, S_OUT
    } t_state;
endpackage
`default_nettype wire

// ===== rtl/irs_div.sv =====
// Iterative restoring divider: 48-bit dividend, 40-bit divisor, one
// quotient bit per cycle. No package dependencies.
`default_nettype none
module irs_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [47:0] i_num,
    input  wire logic [39:0] i_den,
    output logic             o_done,
    output logic [47:0]      o_quot
);
    logic [47:0] r_q, n_q;
    logic [40:0] r_rem, n_rem;
    logic [39:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [40:0] sh;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_done = 1'b0;
        sh = {r_rem[39:0], r_q[47]};
        if (i_start) begin
            n_q = i_num; n_rem = '0; n_den = i_den; n_cnt = 6'd47; n_busy = 1'b1;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_den}) begin
                n_rem = sh - {1'b0, r_den};
                n_q = {r_q[46:0], 1'b1};
            end else begin
                n_rem = sh;
                n_q = {r_q[46:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den; r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ===== rtl/intrinsic_reward_scorer.sv =====
// Top level of the intrinsic reward scorer.
// Depends on irs_pkg and irs_div.
//
// Usage: requests arrive on i_valid/o_ready, one self-state element per
// request. The request flagged last also carries the prediction error and
// produces one reward on o_valid/i_ready; other requests produce nothing.
// For each element, the accepting edge reads the reference memory into a
// register, the next cycle adds the squared distance and, once mature, writes
// back the moved reference element, and the following idle cycle takes the
// next request.
// The last element then runs the history update (ring memory reads of the
// ten most recent entries, one a cycle), the novelty and progress divisions
// and the mean-square division (each on the shared bit-serial divider), a
// 20-step integer square root, the consistency division and a weighted mix.
// After reset, a clearing pass zeroes all 64 reference memory entries,
// during which no request is taken; configuration writes are taken as ever.
// The result sits in an output register until the receiver takes it, and
// requests are still taken meanwhile; a later reward waits in the mix step
// while the previous one is held, which adds that stall to its latency.
`default_nettype none
module intrinsic_reward_scorer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_self_element,
    input  wire logic [15:0] i_pred_error,
    input  wire logic        i_last_element,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_reward
);
    localparam int unsigned HW = irs_pkg::HistW;
    localparam int unsigned DW = irs_pkg::DimW;

    irs_pkg::t_state r_st, n_st;

    // Memories.
    logic [15:0] ref_mem  [irs_pkg::MaxDim];
    logic [15:0] ring_mem [irs_pkg::HistDepth];
    logic [15:0] r_ref_rd, r_ring_rd;
    logic          ref_we, ring_we;
    logic [DW-1:0] ref_wa, ref_ra;
    logic [15:0]   ref_wd;
    logic [HW-1:0] ring_wa, ring_ra;

    // Control and payload registers.
    logic [6:0]    r_len;
    logic [DW:0]   r_clr;
    logic [DW:0]   r_idx, n_idx;
    logic [DW:0]   r_acc_cnt, n_acc_cnt;
    logic [HW:0]   r_fill, n_fill;
    logic [HW-1:0] r_head, n_head;
    logic [20:0]   r_sum, n_sum;
    logic [3:0]    r_calls, n_calls;
    logic [39:0]   r_dacc, n_dacc;
    logic [15:0]   r_s, r_e;
    logic          r_last, r_use;
    logic [3:0]    r_k, n_k;
    logic [18:0]   r_recent, n_recent, r_older, n_older;
    logic [16:0]   r_nov, n_nov, r_prog, n_prog, r_cons, n_cons;
    logic [39:0]   r_msq, n_msq;
    logic [19:0]   r_root, n_root;
    logic [39:0]   r_rem, n_rem;
    logic [5:0]    r_it, n_it;
    logic [15:0]   r_out, n_out;
    logic          r_ovalid, n_ovalid;
    logic          r_mature, n_mature;

    // Divider.
    logic        dv_start, dv_done;
    logic [47:0] dv_num, dv_quot;
    logic [39:0] dv_den;

    irs_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start),
        .i_num(dv_num), .i_den(dv_den), .o_done(dv_done), .o_quot(dv_quot)
    );

    logic [6:0]  eff;
    logic        clearing;
    logic signed [16:0] diff;
    logic [16:0] mag;
    logic [33:0] sq;
    logic [32:0] stepp;
    logic [15:0] stepv;
    logic [21:0] scaled;
    logic [21:0] nov_num, nov_den, eps_fill;
    logic [19:0] pden;
    logic [49:0] mix;
    logic [16:0] qsat;
    logic [21:0] cden;

    assign clearing = !r_clr[DW];
    always_comb begin
        eff = r_len;
        if (eff == 7'd0) eff = 7'd1;
        if (eff > 7'(irs_pkg::MaxDim)) eff = 7'(irs_pkg::MaxDim);
    end

    assign o_ready  = (r_st == irs_pkg::S_IDLE) && !clearing;
    assign o_valid  = r_ovalid;
    assign o_reward = r_out;

    assign diff  = $signed({r_s[15], r_s}) - $signed({r_ref_rd[15], r_ref_rd});
    assign mag   = diff[16] ? 17'(-diff) : 17'(diff);
    assign sq    = 34'(mag) * 34'(mag);
    assign stepp = 33'(mag) * 33'(irs_pkg::AlphaQ16) + 33'd32768;
    assign stepv = stepp[31:16];
    assign scaled   = 22'(r_e) * 22'(r_fill);
    assign eps_fill = 22'(irs_pkg::EpsQ12) * 22'(r_fill);
    assign nov_num  = (scaled > 22'(r_sum)) ? scaled - 22'(r_sum) : 22'(r_sum) - scaled;
    assign nov_den  = (22'(r_sum) > eps_fill) ? 22'(r_sum) : eps_fill;
    assign pden     = (20'(r_older) + 20'(r_recent) < 20'd205) ? 20'd205
                      : 20'(r_older) + 20'(r_recent);
    assign qsat     = (dv_quot > 48'(irs_pkg::OneQ15)) ? irs_pkg::OneQ15 : dv_quot[16:0];
    assign cden     = 22'd4096 + 22'(r_root) * 22'd3;
    assign mix = 50'(r_nov) * 50'(irs_pkg::WNov) + 50'(r_prog) * 50'(irs_pkg::WProg)
               + 50'(r_cons) * 50'(irs_pkg::WCons) + 50'd16384;

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            irs_pkg::S_IDLE:    if (i_valid && o_ready) n_st = irs_pkg::S_ELEM;
            irs_pkg::S_ELEM:    n_st = r_last ? irs_pkg::S_RING : irs_pkg::S_IDLE;
            irs_pkg::S_RING:    n_st = irs_pkg::S_HIST;
            irs_pkg::S_HIST:    n_st = irs_pkg::S_SUMS;
            irs_pkg::S_SUMS:    if (r_k == 4'd11) n_st = irs_pkg::S_NOVDIV;
            irs_pkg::S_NOVDIV:  if (dv_done) n_st = irs_pkg::S_PROGDIV;
            irs_pkg::S_PROGDIV: if (dv_done) n_st = irs_pkg::S_MEAN;
            irs_pkg::S_MEAN:    if (dv_done) n_st = irs_pkg::S_SQRT;
            irs_pkg::S_SQRT:    if (r_it == 6'd20) n_st = irs_pkg::S_CONSDIV;
            irs_pkg::S_CONSDIV: if (dv_done) n_st = irs_pkg::S_MIX;
            irs_pkg::S_MIX:     if (!r_ovalid || i_ready) n_st = irs_pkg::S_OUT;
            irs_pkg::S_OUT:     n_st = irs_pkg::S_IDLE;
            default:            n_st = irs_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_idx = r_idx; n_acc_cnt = r_acc_cnt; n_fill = r_fill; n_head = r_head;
        n_sum = r_sum; n_calls = r_calls; n_dacc = r_dacc; n_k = r_k;
        n_recent = r_recent; n_older = r_older; n_nov = r_nov; n_prog = r_prog;
        n_cons = r_cons; n_msq = r_msq; n_root = r_root; n_rem = r_rem; n_it = r_it;
        n_out = r_out; n_ovalid = r_ovalid; n_mature = r_mature;
        ref_we = 1'b0; ref_wa = r_clr[DW-1:0]; ref_wd = '0; ref_ra = i_valid ?
            r_idx[DW-1:0] : r_idx[DW-1:0];
        ring_we = 1'b0; ring_wa = r_head; ring_ra = r_head;
        dv_start = 1'b0; dv_num = '0; dv_den = 40'd1;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        if (clearing) ref_we = 1'b1;
        unique case (r_st)
            irs_pkg::S_IDLE: begin
                if (i_valid && o_ready) n_mature = (r_calls >= 4'd10);
            end
            irs_pkg::S_ELEM: begin
                if (r_use) begin
                    n_dacc = r_dacc + 40'(sq);
                    n_acc_cnt = r_acc_cnt + (DW+1)'(1);
                    if (r_mature) begin
                        ref_we = 1'b1;
                        ref_wa = r_idx[DW-1:0];
                        ref_wd = diff[16] ? r_ref_rd - stepv : r_ref_rd + stepv;
                    end
                end
                if (r_idx < (DW+1)'(irs_pkg::MaxDim)) n_idx = r_idx + (DW+1)'(1);
                ring_ra = r_head;
            end
            irs_pkg::S_RING: begin
                // r_ring_rd holds the oldest slot, dropped when the ring is full.
                ring_we = 1'b1;
                if (r_fill == (HW+1)'(irs_pkg::HistDepth))
                    n_sum = r_sum - 21'(r_ring_rd) + 21'(r_e);
                else begin
                    n_sum = r_sum + 21'(r_e);
                    n_fill = r_fill + (HW+1)'(1);
                end
                n_head = r_head + HW'(1);
                n_k = '0; n_recent = '0; n_older = '0;
            end
            irs_pkg::S_HIST: begin
                ring_ra = r_head - HW'(1) - HW'(r_k);
                n_k = r_k + 4'd1;
            end
            irs_pkg::S_SUMS: begin
                ring_ra = r_head - HW'(1) - HW'(r_k);
                if (r_k <= 4'd5) n_recent = r_recent + 19'(r_ring_rd);
                else n_older = r_older + 19'(r_ring_rd);
                n_k = r_k + 4'd1;
                if (r_k == 4'd11) begin
                    n_recent = r_recent; n_older = r_older;
                    dv_start = 1'b1;
                    dv_num = {11'd0, nov_num, 15'd0};
                    dv_den = 40'(nov_den);
                end
            end
            irs_pkg::S_NOVDIV: if (dv_done) begin
                n_nov = (r_fill >= (HW+1)'(5)) ? qsat : '0;
                dv_start = 1'b1;
                dv_num = (r_older > r_recent) ? {14'd0, 19'(r_older - r_recent), 15'd0} : '0;
                dv_den = 40'(pden);
            end
            irs_pkg::S_PROGDIV: if (dv_done) begin
                n_prog = (r_fill >= (HW+1)'(10) && r_older > r_recent) ? qsat : '0;
                dv_start = 1'b1;
                dv_num = 48'(r_dacc);
                dv_den = (r_acc_cnt == '0) ? 40'd1 : 40'(r_acc_cnt);
            end
            irs_pkg::S_MEAN: if (dv_done) begin
                n_msq = dv_quot[39:0];
                n_root = '0; n_rem = '0; n_it = '0;
            end
            irs_pkg::S_SQRT: begin
                // One result bit a step, two radicand bits shifted in.
                if (r_it != 6'd20) begin
                    if ({r_rem[37:0], r_msq[39:38]} >= {18'd0, r_root, 2'b01}) begin
                        n_rem = {r_rem[37:0], r_msq[39:38]} - {18'd0, r_root, 2'b01};
                        n_root = {r_root[18:0], 1'b1};
                    end else begin
                        n_rem = {r_rem[37:0], r_msq[39:38]};
                        n_root = {r_root[18:0], 1'b0};
                    end
                    n_msq = {r_msq[37:0], 2'b00};
                    n_it = r_it + 6'd1;
                end else begin
                    dv_start = 1'b1;
                    dv_num = 48'd134217728;
                    dv_den = 40'(cden);
                end
            end
            irs_pkg::S_CONSDIV: if (dv_done)
                n_cons = r_mature ? dv_quot[16:0] : 17'd16384;
            irs_pkg::S_MIX: begin
                // The reward is loaded only once the output register is free.
                if (!r_ovalid || i_ready)
                    n_out = (mix[49:15] > 35'(irs_pkg::OneQ15)) ? 16'h8000 : mix[30:15];
            end
            irs_pkg::S_OUT: begin
                n_ovalid = 1'b1;
                if (r_calls < 4'd11) n_calls = r_calls + 4'd1;
                n_dacc = '0; n_idx = '0; n_acc_cnt = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ref_we) ref_mem[ref_wa] <= ref_wd;
        r_ref_rd <= ref_mem[ref_ra];
        if (ring_we) ring_mem[ring_wa] <= r_e;
        r_ring_rd <= ring_mem[ring_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= irs_pkg::S_IDLE; r_len <= 7'd16; r_clr <= '0;
            r_idx <= '0; r_acc_cnt <= '0; r_fill <= '0; r_head <= '0;
            r_sum <= '0; r_calls <= '0; r_dacc <= '0; r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) r_len <= i_cfg_wdata;
            if (clearing) r_clr <= r_clr + (DW+1)'(1);
            r_idx <= n_idx; r_acc_cnt <= n_acc_cnt; r_fill <= n_fill;
            r_head <= n_head; r_sum <= n_sum; r_calls <= n_calls;
            r_dacc <= n_dacc; r_ovalid <= n_ovalid;
        end
        if (i_valid && o_ready) begin
            r_s <= i_self_element; r_e <= i_pred_error; r_last <= i_last_element;
            r_use <= (7'(r_idx) < eff);
        end
        r_k <= n_k; r_recent <= n_recent; r_older <= n_older;
        r_nov <= n_nov; r_prog <= n_prog; r_cons <= n_cons;
        r_msq <= n_msq; r_root <= n_root; r_rem <= n_rem; r_it <= n_it;
        r_out <= n_out; r_mature <= n_mature;
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != irs_pkg::S_IDLE) |-> !o_ready) else $error("request taken while busy");
    a_reward_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_reward <= 16'h8000)) else $error("reward above one");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (HW+1)'(irs_pkg::HistDepth)) else $error("ring fill overflow");
`endif
endmodule
`default_nettype wire
